// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Holds nothing but the include guard and the macro bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define BRLE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error(msg);

// Clocked assertion that also holds across reset.
`define BRLE_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
   else $error(msg);

`endif

// File: hdl/brle_pkg.sv
// Package of the byte-map run-length unpacker: widths, queue sizes,
// register address and the words that pass between the modules. No dependencies.
`default_nettype none

package brle_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 32;

   // Flag byte values at the head of a stream.
   localparam logic [BYTE_W-1:0] FLAG_STORED = 8'd0;
   localparam logic [BYTE_W-1:0] FLAG_CODED  = 8'd1;

   // Input queue between the front and the decoder (depth a power of two).
   localparam int IN_Q_DEPTH = 2;
   localparam int IN_PTR_W   = $clog2(IN_Q_DEPTH);
   localparam int IN_CNT_W   = $clog2(IN_Q_DEPTH + 1);

   // Result queue in front of the result ports (depth a power of two).
   localparam int RSP_Q_DEPTH = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_Q_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_Q_DEPTH + 1);

   // Register port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_EXPECTED = 2'd0;

   // One classified input word.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              zero_byte;
      logic              one_byte;
   } byte_word_type;

   // One result word.
   typedef struct packed {
      logic [BYTE_W-1:0]  value;
      logic [COUNT_W-1:0] count;
      logic               step_last;
      logic               stream_done;
      logic               corrupt;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hdl/brle_front.sv
// Front of the unpacker: accepts input words, classifies each byte and holds
// them in a short queue for the decoder. Depends on brle_pkg.
`default_nettype none

module brle_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire logic [brle_pkg::BYTE_W-1:0] req_in_byte,
   input  wire logic                      req_last_byte,
   output logic                           dec_valid,
   output brle_pkg::byte_word_type        dec_word,
   input  wire logic                      dec_pop
);
   import brle_pkg::*;

   byte_word_type       mem_ff [IN_Q_DEPTH];
   logic [IN_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IN_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IN_CNT_W-1:0] count_ff, count_in;
   logic                wr_en;
   logic                rd_en;
   byte_word_type       new_word;

   // Classify the byte on the way in.
   always_comb begin
      new_word.data      = req_in_byte;
      new_word.last      = req_last_byte;
      new_word.zero_byte = (req_in_byte == FLAG_STORED);
      new_word.one_byte  = (req_in_byte == FLAG_CODED);
   end

   assign full      = (count_ff == IN_CNT_W'(IN_Q_DEPTH));
   assign dec_valid = (count_ff != '0);
   assign dec_word  = mem_ff[rd_ptr_ff];
   assign wr_en     = push && !full;
   assign rd_en     = dec_pop && dec_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + IN_PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + IN_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + IN_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - IN_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= new_word;
      end
   end

endmodule

`default_nettype wire

// File: hdl/brle_engine.sv
// Decoder of the unpacker: unless stalled, consumes one byte per cycle, walks
// control-byte codes one per cycle, stages result words. Depends on brle_pkg.
`default_nettype none

module brle_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [brle_pkg::COUNT_W-1:0]  expected_length,
   input  wire logic                          dec_valid,
   input  wire brle_pkg::byte_word_type       dec_word,
   output logic                               dec_pop,
   input  wire logic                          rsp_room,
   output logic                               rsp_push,
   output brle_pkg::rsp_word_type             rsp_word
);
   import brle_pkg::*;

   // Decoder phases.
   localparam logic [3:0] PH_FLAG  = 4'd0;
   localparam logic [3:0] PH_COPY  = 4'd1;
   localparam logic [3:0] PH_CTRL  = 4'd2;
   localparam logic [3:0] PH_VALUE = 4'd3;
   localparam logic [3:0] PH_LEN   = 4'd4;
   localparam logic [3:0] PH_LONG  = 4'd5;
   localparam logic [3:0] PH_LIT   = 4'd6;
   localparam logic [3:0] PH_FULL  = 4'd7;
   localparam logic [3:0] PH_DRAIN = 4'd8;

   // Two-bit codes of a control byte, and the empty pending slot.
   localparam logic [1:0] CODE_ZERO = 2'd0;
   localparam logic [1:0] CODE_PREV = 2'd1;
   localparam logic [1:0] CODE_RUN  = 2'd2;
   localparam logic [1:0] CODE_NEW  = 2'd3;
   localparam logic [2:0] NO_CODE   = 3'd4;

   localparam logic [COUNT_W-1:0] ONE_COUNT = COUNT_W'(1);

   // Stream state.
   logic [3:0]          phase_ff, phase_in;
   logic                walk_ff, walk_in;
   logic [BYTE_W-1:0]   ctl_ff, ctl_in;
   logic [2:0]          codes_left_ff, codes_left_in;
   logic [2:0]          pending_ff, pending_in;
   logic [BYTE_W-1:0]   prev_lit_ff, prev_lit_in;
   logic [BYTE_W-1:0]   run_value_ff, run_value_in;
   logic [COUNT_W-1:0]  run_acc_ff, run_acc_in;
   logic [1:0]          len_seen_ff, len_seen_in;
   logic [COUNT_W-1:0]  remain_ff, remain_in;
   logic                error_ff, error_in;
   logic                last_ff, last_in;
   logic                emitted_ff, emitted_in;

   // Staged result word and its closing tags.
   logic                stage_valid_ff, stage_valid_in;
   logic                stage_closed_ff, stage_closed_in;
   logic                stage_done_ff, stage_done_in;
   logic                stage_corrupt_ff, stage_corrupt_in;
   logic [BYTE_W-1:0]   stage_value_ff, stage_value_in;
   logic [COUNT_W-1:0]  stage_count_ff, stage_count_in;

   // Per-cycle work signals.
   logic                adv;
   logic                emit;
   logic [BYTE_W-1:0]   emit_value;
   logic [COUNT_W-1:0]  emit_count;
   logic                do_run;
   logic [COUNT_W-1:0]  run_len;
   logic [1:0]          code;
   logic [2:0]          codes_dec;
   logic                step_end;
   logic                cur_last;
   logic                stream_ok;
   logic                status_only;
   logic                new_write;

   assign code      = ctl_ff[1:0];
   assign codes_dec = codes_left_ff - 3'd1;

   // The decoder moves when it has work and the stage can be emptied if needed.
   assign adv     = (walk_ff || dec_valid) && (!stage_valid_ff || rsp_room);
   assign dec_pop = adv && !walk_ff;

   // Next stream state: one byte or one code per cycle when the decoder advances.
   always_comb begin
      phase_in      = phase_ff;
      walk_in       = walk_ff;
      ctl_in        = ctl_ff;
      codes_left_in = codes_left_ff;
      pending_in    = pending_ff;
      prev_lit_in   = prev_lit_ff;
      run_value_in  = run_value_ff;
      run_acc_in    = run_acc_ff;
      len_seen_in   = len_seen_ff;
      remain_in     = remain_ff;
      error_in      = error_ff;
      last_in       = last_ff;
      emit          = 1'b0;
      emit_value    = '0;
      emit_count    = ONE_COUNT;
      do_run        = 1'b0;
      run_len       = '0;
      stream_ok     = 1'b0;

      if (adv && walk_ff) begin
         // One step of the code walk.
         if (remain_ff == '0) begin
            phase_in = PH_FULL;
            walk_in  = 1'b0;
         end else if (codes_left_ff == '0) begin
            phase_in = PH_CTRL;
            walk_in  = 1'b0;
         end else begin
            ctl_in        = ctl_ff >> 2;
            codes_left_in = codes_dec;
            if (codes_dec == '0) begin
               // The fourth code waits for the next control byte.
               pending_in = {1'b0, code};
               phase_in   = PH_CTRL;
               walk_in    = 1'b0;
            end else begin
               case (code)
                  CODE_ZERO: begin
                     emit      = 1'b1;
                     remain_in = remain_ff - ONE_COUNT;
                  end
                  CODE_PREV: begin
                     emit       = 1'b1;
                     emit_value = prev_lit_ff;
                     remain_in  = remain_ff - ONE_COUNT;
                  end
                  CODE_NEW: begin
                     phase_in = PH_LIT;
                     walk_in  = 1'b0;
                  end
                  default: begin
                     phase_in = PH_VALUE;
                     walk_in  = 1'b0;
                  end
               endcase
            end
         end
      end else if (adv) begin
         // A byte from the input queue.
         last_in = dec_word.last;
         case (phase_ff)
            PH_FLAG: begin
               ctl_in        = '0;
               codes_left_in = '0;
               pending_in    = NO_CODE;
               prev_lit_in   = '0;
               run_value_in  = '0;
               run_acc_in    = '0;
               len_seen_in   = '0;
               error_in      = 1'b0;
               remain_in     = expected_length;
               if (dec_word.zero_byte) begin
                  phase_in = PH_COPY;
               end else if (dec_word.one_byte) begin
                  phase_in = PH_CTRL;
               end else begin
                  error_in = 1'b1;
                  phase_in = PH_DRAIN;
               end
            end
            PH_COPY: begin
               if (remain_ff == '0) begin
                  error_in = 1'b1;
                  phase_in = PH_DRAIN;
               end else begin
                  emit       = 1'b1;
                  emit_value = dec_word.data;
                  remain_in  = remain_ff - ONE_COUNT;
               end
            end
            PH_CTRL: begin
               ctl_in        = dec_word.data;
               codes_left_in = 3'd4;
               walk_in       = 1'b1;
               // A held fourth code acts before the new control byte's codes.
               if (pending_ff != NO_CODE) begin
                  pending_in = NO_CODE;
                  case (pending_ff[1:0])
                     CODE_ZERO: begin
                        emit      = 1'b1;
                        remain_in = remain_ff - ONE_COUNT;
                     end
                     CODE_PREV: begin
                        emit       = 1'b1;
                        emit_value = prev_lit_ff;
                        remain_in  = remain_ff - ONE_COUNT;
                     end
                     CODE_NEW: begin
                        phase_in = PH_LIT;
                        walk_in  = 1'b0;
                     end
                     default: begin
                        phase_in = PH_VALUE;
                        walk_in  = 1'b0;
                     end
                  endcase
               end
            end
            PH_VALUE: begin
               run_value_in = dec_word.data;
               phase_in     = PH_LEN;
            end
            PH_LEN: begin
               if (!dec_word.zero_byte) begin
                  do_run  = 1'b1;
                  run_len = {{(COUNT_W-BYTE_W){1'b0}}, dec_word.data};
               end else begin
                  run_acc_in  = '0;
                  len_seen_in = '0;
                  phase_in    = PH_LONG;
               end
            end
            PH_LONG: begin
               run_acc_in = {run_acc_ff[COUNT_W-BYTE_W-1:0], dec_word.data};
               if (len_seen_ff == 2'd3) begin
                  do_run  = 1'b1;
                  run_len = run_acc_in;
               end else begin
                  len_seen_in = len_seen_ff + 2'd1;
               end
            end
            PH_LIT: begin
               prev_lit_in = dec_word.data;
               emit        = 1'b1;
               emit_value  = dec_word.data;
               remain_in   = remain_ff - ONE_COUNT;
               walk_in     = 1'b1;
            end
            PH_FULL: begin
               error_in = 1'b1;
               phase_in = PH_DRAIN;
            end
            default: begin
            end
         endcase

         // End of a run: check it against what is still owed.
         if (do_run) begin
            if (run_len > remain_ff) begin
               error_in = 1'b1;
               phase_in = PH_DRAIN;
            end else begin
               remain_in = remain_ff - run_len;
               walk_in   = 1'b1;
               if (run_len != '0) begin
                  emit       = 1'b1;
                  emit_value = run_value_ff;
                  emit_count = run_len;
               end
            end
         end
      end

      cur_last = last_in;
      step_end = adv && !walk_in;

      // Final status, then a fresh stream after the last byte.
      stream_ok = !error_in &&
                  ((phase_in == PH_FULL) || ((phase_in == PH_COPY) && (remain_in == '0)));
      if (step_end && cur_last) begin
         phase_in      = PH_FLAG;
         ctl_in        = '0;
         codes_left_in = '0;
         pending_in    = NO_CODE;
         prev_lit_in   = '0;
         run_value_in  = '0;
         run_acc_in    = '0;
         len_seen_in   = '0;
         remain_in     = '0;
         error_in      = 1'b0;
      end
   end

   // Results of the current step so far.
   assign status_only = step_end && cur_last && !emitted_ff && !emit;
   assign new_write   = emit || status_only;

   always_comb begin
      emitted_in = emitted_ff;
      if (adv) begin
         emitted_in = step_end ? 1'b0 : (emitted_ff || emit);
      end
   end

   // The stage leaves for the result queue when closed or when displaced.
   assign rsp_push = stage_valid_ff && rsp_room && (stage_closed_ff || (adv && new_write));

   always_comb begin
      rsp_word.value       = stage_value_ff;
      rsp_word.count       = stage_count_ff;
      rsp_word.step_last   = stage_closed_ff;
      rsp_word.stream_done = stage_done_ff;
      rsp_word.corrupt     = stage_corrupt_ff;
   end

   // Stage update: a new word, a closing of the current word, or a drain.
   always_comb begin
      stage_valid_in   = stage_valid_ff;
      stage_closed_in  = stage_closed_ff;
      stage_done_in    = stage_done_ff;
      stage_corrupt_in = stage_corrupt_ff;
      stage_value_in   = stage_value_ff;
      stage_count_in   = stage_count_ff;
      if (adv && new_write) begin
         stage_valid_in   = 1'b1;
         stage_closed_in  = step_end;
         stage_done_in    = step_end && cur_last;
         stage_corrupt_in = step_end && cur_last && !stream_ok;
         stage_value_in   = status_only ? '0 : emit_value;
         stage_count_in   = status_only ? '0 : emit_count;
      end else if (adv && step_end && stage_valid_ff && !stage_closed_ff) begin
         stage_closed_in  = 1'b1;
         stage_done_in    = cur_last;
         stage_corrupt_in = cur_last && !stream_ok;
      end else if (rsp_push) begin
         stage_valid_in  = 1'b0;
         stage_closed_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_FLAG;
         walk_ff         <= 1'b0;
         codes_left_ff   <= '0;
         pending_ff      <= NO_CODE;
         error_ff        <= 1'b0;
         last_ff         <= 1'b0;
         emitted_ff      <= 1'b0;
         stage_valid_ff  <= 1'b0;
         stage_closed_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         walk_ff         <= walk_in;
         codes_left_ff   <= codes_left_in;
         pending_ff      <= pending_in;
         error_ff        <= error_in;
         last_ff         <= last_in;
         emitted_ff      <= emitted_in;
         stage_valid_ff  <= stage_valid_in;
         stage_closed_ff <= stage_closed_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      ctl_ff           <= ctl_in;
      prev_lit_ff      <= prev_lit_in;
      run_value_ff     <= run_value_in;
      run_acc_ff       <= run_acc_in;
      len_seen_ff      <= len_seen_in;
      remain_ff        <= remain_in;
      stage_done_ff    <= stage_done_in;
      stage_corrupt_ff <= stage_corrupt_in;
      stage_value_ff   <= stage_value_in;
      stage_count_ff   <= stage_count_in;
   end

endmodule

`default_nettype wire

// File: hdl/brle_rsp_q.sv
// Result queue of the unpacker: holds result words and presents the oldest
// one on the result ports. Depends on brle_pkg.
`default_nettype none

module brle_rsp_q (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_push,
   input  wire brle_pkg::rsp_word_type         wr_word,
   output logic                                wr_room,
   output logic                                empty,
   input  wire logic                           pop,
   output logic [brle_pkg::BYTE_W-1:0]         rsp_out_value,
   output logic [brle_pkg::COUNT_W-1:0]        rsp_repeat_count,
   output logic                                rsp_step_last,
   output logic                                rsp_stream_done,
   output logic                                rsp_corrupt
);
   import brle_pkg::*;

   rsp_word_type         mem_ff [RSP_Q_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 wr_en;
   logic                 rd_en;
   rsp_word_type         head;

   assign wr_room = (count_ff != RSP_CNT_W'(RSP_Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_en   = wr_push && wr_room;
   assign rd_en   = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   assign rsp_out_value    = head.value;
   assign rsp_repeat_count = head.count;
   assign rsp_step_last    = head.step_last;
   assign rsp_stream_done  = head.stream_done;
   assign rsp_corrupt      = head.corrupt;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

`default_nettype wire

// File: hdl/bytemap_rle_unpacker_top.sv
// Top level of the byte-map run-length unpacker: register port, front queue,
// decoder and result queue. Depends on brle_pkg, brle_front, brle_engine, brle_rsp_q.
//
//   Channel   Handshake              Payload
//   input     push / full            req_in_byte, req_last_byte
//   result    empty / pop            rsp_out_value, rsp_repeat_count, rsp_step_last,
//                                    rsp_stream_done, rsp_corrupt
//   register  psel, penable, pwrite  paddr, pwdata, prdata (expected_length at 0)
//
// The decoder consumes a data, flag, value or length byte by itself. A control byte
// or a literal or run that resumes the code walk is followed by one walk step for
// each code walked; the code walker in the decoder emits at most one result word
// per cycle.
// Reset is synchronous and empties both queues; no clearing pass is needed.
// A full result queue stalls the decoder, which in turn fills the input queue.
`default_nettype none

module bytemap_rle_unpacker_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic [brle_pkg::BYTE_W-1:0]        req_in_byte,
   input  wire logic                               req_last_byte,
   output logic                                    empty,
   input  wire logic                               pop,
   output logic [brle_pkg::BYTE_W-1:0]             rsp_out_value,
   output logic [brle_pkg::COUNT_W-1:0]            rsp_repeat_count,
   output logic                                    rsp_step_last,
   output logic                                    rsp_stream_done,
   output logic                                    rsp_corrupt,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [brle_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [brle_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [brle_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);
   import brle_pkg::*;

   logic [COUNT_W-1:0] expected_ff, expected_in;
   logic               csr_write;
   logic               dec_valid;
   byte_word_type      dec_word;
   logic               dec_pop;
   logic               rsp_room;
   logic               rsp_push;
   rsp_word_type       rsp_word;

   // Register port: always ready, one register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == CSR_ADDR_EXPECTED);
   assign prdata    = (paddr == CSR_ADDR_EXPECTED) ? expected_ff : '0;

   always_comb begin
      expected_in = expected_ff;
      if (csr_write) begin
         expected_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else begin
         expected_ff <= expected_in;
      end
   end

   // Input side.
   brle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .dec_valid     (dec_valid),
      .dec_word      (dec_word),
      .dec_pop       (dec_pop)
   );

   // Decoder.
   brle_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .expected_length (expected_ff),
      .dec_valid       (dec_valid),
      .dec_word        (dec_word),
      .dec_pop         (dec_pop),
      .rsp_room        (rsp_room),
      .rsp_push        (rsp_push),
      .rsp_word        (rsp_word)
   );

   // Result side.
   brle_rsp_q u_rsp_q (
      .clock            (clock),
      .reset            (reset),
      .wr_push          (rsp_push),
      .wr_word          (rsp_word),
      .wr_room          (rsp_room),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_value    (rsp_out_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_step_last    (rsp_step_last),
      .rsp_stream_done  (rsp_stream_done),
      .rsp_corrupt      (rsp_corrupt)
   );

endmodule

`default_nettype wire

// File: hdl/brle_checker.sv
// Port checker of the byte-map run-length unpacker and its bind to the top level.
// Depends on assert_macros.svh and brle_pkg.
`default_nettype none
`include "assert_macros.svh"

module brle_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire logic                               full,
   input  wire logic [brle_pkg::BYTE_W-1:0]        req_in_byte,
   input  wire logic                               req_last_byte,
   input  wire logic                               empty,
   input  wire logic                               pop,
   input  wire logic [brle_pkg::BYTE_W-1:0]        rsp_out_value,
   input  wire logic [brle_pkg::COUNT_W-1:0]       rsp_repeat_count,
   input  wire logic                               rsp_step_last,
   input  wire logic                               rsp_stream_done,
   input  wire logic                               rsp_corrupt,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [brle_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [brle_pkg::CSR_DATA_W-1:0]    pwdata,
   input  wire logic [brle_pkg::CSR_DATA_W-1:0]    prdata,
   input  wire logic                               pready
);
   import brle_pkg::*;

   logic                      zero_count;
   logic                      status_word;
   logic                      rsp_wait;
   logic [BYTE_W+COUNT_W-1:0] head_bits;

   // Shorthands for the result side.
   assign zero_count  = !empty && (rsp_repeat_count == '0);
   assign status_word = rsp_stream_done && (rsp_out_value == '0);
   assign rsp_wait    = !empty && !pop;
   assign head_bits   = {rsp_out_value, rsp_repeat_count};

   // Final status only rides on the last word of a step.
   `BRLE_ASSERT(a_done_last, (!empty && rsp_stream_done) |-> rsp_step_last, "done off step end")

   // A corrupt mark comes only with the end of a stream.
   `BRLE_ASSERT(a_corrupt_done, (!empty && rsp_corrupt) |-> rsp_stream_done, "corrupt alone")

   // A word with no copies is a status-only word.
   `BRLE_ASSERT(a_status_shape, zero_count |-> status_word, "zero count on a run word")

   // Once reset has been applied the result queue is empty and the input queue is not full.
   `BRLE_ASSERT_RST(a_reset_empty, reset |=> (empty && !full), "not empty after reset")

   // A waiting result word holds until it is taken.
   `BRLE_ASSERT(a_rsp_hold, rsp_wait |=> (!empty && $stable(head_bits)), "held word changed")

endmodule

bind bytemap_rle_unpacker_top brle_checker u_checker (.*);

`default_nettype wire
